// ===== rtl/core/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, vertex codes and helpers for the triangle colour subdivider.
// ----------------------------------------------------------------------------
package tcs_pkg;

  typedef struct packed {
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } colour_t;

  // vertex codes: corners and edge midpoints of a triangle
  localparam logic [2:0] V_A  = 3'd0;
  localparam logic [2:0] V_B  = 3'd1;
  localparam logic [2:0] V_C  = 3'd2;
  localparam logic [2:0] V_AB = 3'd3;
  localparam logic [2:0] V_BC = 3'd4;
  localparam logic [2:0] V_CA = 3'd5;

  localparam logic [3:0] LAST_VTX = 4'd11;
  localparam logic [1:0] LAST_SUB = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       top_mid;
    logic       load_cur;
    logic       direct;
    logic [1:0] sub_sel;
    logic       cur_mid;
    logic       emit;
    logic [3:0] vtx;
    logic       last;
  } cmd_t;

  // channel-wise floor average
  function automatic colour_t mid_of(input colour_t p, input colour_t q);
    logic [8:0] s0, s1, s2;
    colour_t    r;
    s0 = {1'b0, p.c0} + {1'b0, q.c0};
    s1 = {1'b0, p.c1} + {1'b0, q.c1};
    s2 = {1'b0, p.c2} + {1'b0, q.c2};
    r.c0 = s0[8:1];
    r.c1 = s1[8:1];
    r.c2 = s2[8:1];
    return r;
  endfunction

  // twelve corners of the four sub-triangles; group k is sub-triangle k
  function automatic logic [2:0] emit_code(input logic [3:0] idx);
    logic [2:0] code;
    case (idx)
      4'd0:    code = V_A;
      4'd1:    code = V_AB;
      4'd2:    code = V_CA;
      4'd3:    code = V_B;
      4'd4:    code = V_BC;
      4'd5:    code = V_AB;
      4'd6:    code = V_C;
      4'd7:    code = V_CA;
      4'd8:    code = V_BC;
      4'd9:    code = V_BC;
      4'd10:   code = V_CA;
      4'd11:   code = V_AB;
      default: code = V_A;
    endcase
    return code;
  endfunction

  function automatic colour_t pick_vertex(input logic [2:0] code,
                                          input colour_t a, input colour_t b,
                                          input colour_t c, input colour_t ab,
                                          input colour_t bc, input colour_t ca);
    colour_t r;
    case (code)
      V_A:     r = a;
      V_B:     r = b;
      V_C:     r = c;
      V_AB:    r = ab;
      V_BC:    r = bc;
      V_CA:    r = ca;
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/triangle_colour_subdivider_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_colour_subdivider_unit
// Midpoint subdivision of a colour triangle, one emitted vertex per strobe.
// ----------------------------------------------------------------------------
// sequence: accept loads the corners; two levels add the top midpoints; then each
//   run loads a triangle and its midpoints, then results come one per cycle in runs of 12
// an item is finished before the next is taken: start is accepted only while
//   the sequencer is idle (one run at one level, four runs at two levels)
// reset: synchronous active-high rst clears the sequencer and the strobe
// results cannot be stalled; each is valid for exactly its strobe cycle
module triangle_colour_subdivider_unit #(
  parameter int MAX_LEVELS = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] va_c0,
  input  logic [7:0] va_c1,
  input  logic [7:0] va_c2,
  input  logic [7:0] vb_c0,
  input  logic [7:0] vb_c1,
  input  logic [7:0] vb_c2,
  input  logic [7:0] vc_c0,
  input  logic [7:0] vc_c1,
  input  logic [7:0] vc_c2,
  input  logic [1:0] levels,
  output logic       strobe,
  output logic [7:0] out_c0,
  output logic [7:0] out_c1,
  output logic [7:0] out_c2,
  output logic       last
);

  tcs_pkg::cmd_t    cmd;
  tcs_pkg::colour_t in_a, in_b, in_c, out_colour;

  // pack corner channels
  assign in_a = '{c2: va_c2, c1: va_c1, c0: va_c0};
  assign in_b = '{c2: vb_c2, c1: vb_c1, c0: vb_c0};
  assign in_c = '{c2: vc_c2, c1: vc_c1, c0: vc_c0};

  // sequencer: level flag, sub-triangle index, vertex index
  tcs_ctrl #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .levels (levels),
    .busy   (busy),
    .cmd    (cmd)
  );

  // triangle storage, midpoint adders, registered result
  tcs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_a       (in_a),
    .in_b       (in_b),
    .in_c       (in_c),
    .out_colour (out_colour),
    .out_strobe (strobe),
    .out_last   (last)
  );

  assign out_c0 = out_colour.c0;
  assign out_c1 = out_colour.c1;
  assign out_c2 = out_colour.c2;

endmodule

// ===== rtl/core/tcs_datapath.sv =====
// ----------------------------------------------------------------------------
// tcs_datapath
// Triangle registers, midpoint registers and the registered result port.
// ----------------------------------------------------------------------------
module tcs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tcs_pkg::cmd_t     cmd,
  input  tcs_pkg::colour_t  in_a,
  input  tcs_pkg::colour_t  in_b,
  input  tcs_pkg::colour_t  in_c,
  output tcs_pkg::colour_t  out_colour,
  output logic              out_strobe,
  output logic              out_last
);

  tcs_pkg::colour_t ta, tb, tc, tab, tbc, tca;
  tcs_pkg::colour_t ca_r, cb_r, cc_r, cab, cbc, cca;
  tcs_pkg::colour_t sub_a, sub_b, sub_c;
  logic [3:0]       base;

  // corner slots of the selected sub-triangle
  assign base  = {2'b00, cmd.sub_sel} + {1'b0, cmd.sub_sel, 1'b0};
  assign sub_a = tcs_pkg::pick_vertex(tcs_pkg::emit_code(base),
                                      ta, tb, tc, tab, tbc, tca);
  assign sub_b = tcs_pkg::pick_vertex(tcs_pkg::emit_code(base + 4'd1),
                                      ta, tb, tc, tab, tbc, tca);
  assign sub_c = tcs_pkg::pick_vertex(tcs_pkg::emit_code(base + 4'd2),
                                      ta, tb, tc, tab, tbc, tca);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ta <= in_a;
      tb <= in_b;
      tc <= in_c;
    end
    if (cmd.top_mid) begin
      tab <= tcs_pkg::mid_of(ta, tb);
      tbc <= tcs_pkg::mid_of(tb, tc);
      tca <= tcs_pkg::mid_of(tc, ta);
    end
    if (cmd.load_cur) begin
      if (cmd.direct) begin
        ca_r <= ta;
        cb_r <= tb;
        cc_r <= tc;
      end else begin
        ca_r <= sub_a;
        cb_r <= sub_b;
        cc_r <= sub_c;
      end
    end
    if (cmd.cur_mid) begin
      cab <= tcs_pkg::mid_of(ca_r, cb_r);
      cbc <= tcs_pkg::mid_of(cb_r, cc_r);
      cca <= tcs_pkg::mid_of(cc_r, ca_r);
    end
    if (cmd.emit) begin
      out_colour <= tcs_pkg::pick_vertex(tcs_pkg::emit_code(cmd.vtx),
                                         ca_r, cb_r, cc_r, cab, cbc, cca);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
      out_last   <= cmd.emit && cmd.last;
    end
  end

endmodule

// ===== rtl/core/tcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: top midpoints, sub-triangle loads and the twelve-vertex emit run.
// ----------------------------------------------------------------------------
module tcs_ctrl #(
  parameter int MAX_LEVELS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     levels,
  output logic           busy,
  output tcs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TMID = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CMID = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state, state_next;
  logic       deep, deep_next;
  logic [1:0] sub, sub_next;
  logic [3:0] vtx, vtx_next;
  logic       accept, final_vtx;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign final_vtx = (vtx == tcs_pkg::LAST_VTX) && (!deep || sub == tcs_pkg::LAST_SUB);

  always_comb begin
    state_next = state;
    deep_next  = deep;
    sub_next   = sub;
    vtx_next   = vtx;
    cmd        = '0;
    cmd.sub_sel = sub;
    cmd.direct  = !deep;
    cmd.vtx     = vtx;
    cmd.last    = final_vtx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          deep_next   = (MAX_LEVELS >= 2) && (levels >= 2'd2);
          sub_next    = 2'd0;
          vtx_next    = 4'd0;
          state_next  = ((MAX_LEVELS >= 2) && (levels >= 2'd2)) ? S_TMID : S_LOAD;
        end
      end
      S_TMID: begin
        cmd.top_mid = 1'b1;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_cur = 1'b1;
        state_next   = S_CMID;
      end
      S_CMID: begin
        cmd.cur_mid = 1'b1;
        vtx_next    = 4'd0;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (vtx == tcs_pkg::LAST_VTX) begin
          vtx_next = 4'd0;
          if (final_vtx) begin
            sub_next   = 2'd0;
            state_next = S_IDLE;
          end else begin
            sub_next   = sub + 2'd1;
            state_next = S_LOAD;
          end
        end else begin
          vtx_next = vtx + 4'd1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      deep  <= 1'b0;
      sub   <= 2'd0;
      vtx   <= 4'd0;
    end else begin
      state <= state_next;
      deep  <= deep_next;
      sub   <= sub_next;
      vtx   <= vtx_next;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_vtx_range: assert property (@(posedge clk) disable iff (rst)
    vtx <= tcs_pkg::LAST_VTX)
    else $error("vertex counter out of range");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && final_vtx) |=> (state == S_IDLE))
    else $error("final vertex not followed by idle");

  a_sub_deep: assert property (@(posedge clk) disable iff (rst)
    (sub != 2'd0) |-> deep)
    else $error("sub-triangle advanced on a single-level item");

endmodule
